FILE: sv/tchd_pkg.sv
// ----------------------------------------------------------------------------
// tchd_pkg
// Shared types, constants and the arctangent table for the compass heading core.
// ----------------------------------------------------------------------------
package tchd_pkg;

  localparam int CordicStepsDefault = 16;
  localparam int CordicStepsMax     = 24;

  // Reject flag bit positions
  localparam int FlagMag   = 0;
  localparam int FlagTrust = 1;
  localparam int FlagQuat  = 2;
  localparam int FlagHoriz = 3;

  // Configuration register indexes
  localparam logic CfgRequireTrusted = 1'b0;
  localparam logic CfgMinNorm        = 1'b1;

  localparam int InDataW  = 144;
  localparam int InUserW  = 2;
  localparam int OutDataW = 216;
  localparam int OutUserW = 5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_CHK,
    S_NUM,
    S_DSET,
    S_DIV,
    S_SQ,
    S_ROOT,
    S_HCHK,
    S_CSET,
    S_CROT,
    S_DONE
  } state_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/tilt_compensated_mag_heading_core.sv
// ----------------------------------------------------------------------------
// tilt_compensated_mag_heading_core
// Rotates a magnetometer vector into the world frame with a quaternion and
// forms field, north and attitude yaws and their innovation.
// ----------------------------------------------------------------------------
// An accepted sample runs the full path through the CORDIC stage; an early reject
// goes from the check straight to the result, a horizontal reject after the root.
// A new request is taken only in idle, after the last result is loaded; all steps
// share one 35x18 multiplier, one restoring divider step and one CORDIC stage.
// A result waits in the output register while the next request is taken.
// Reset (synchronous) clears counters, configuration and the sequencer.
module tilt_compensated_mag_heading_core #(
  parameter int CORDIC_STEPS = tchd_pkg::CordicStepsDefault  // range 8..24
) (
  input  logic                          clk,
  input  logic                          rst,
  // mag_x, mag_y, mag_z, quat_w, quat_x, quat_y, quat_z, now_ms
  input  logic [tchd_pkg::InDataW-1:0]  s_tdata,
  // mag_ok, mag_trusted
  input  logic [tchd_pkg::InUserW-1:0]  s_tuser,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // world_x, world_y, horizontal_norm, field_yaw, north_yaw, ahrs_yaw,
  // innovation, attempt_total, valid_total, last_valid_time, zero pad
  output logic [tchd_pkg::OutDataW-1:0] m_tdata,
  // heading_valid, reject_flags[3:0]
  output logic [tchd_pkg::OutUserW-1:0] m_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data
);
  import tchd_pkg::*;

  localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

  state_t state, state_next;
  logic [4:0] cnt;
  logic       sel;

  logic        require_trusted;
  logic [15:0] min_norm;

  logic signed [15:0] mx, my, mz, qw, qx, qy, qz;
  logic [31:0] now_r;
  logic signed [31:0] pr [0:9];
  logic [3:0]  flags;
  logic [3:0]  flags_in;
  logic signed [53:0] acc;

  logic        dneg, dsat;
  logic [33:0] drem;
  logic [16:0] dlow, dq;

  logic signed [16:0] wx, wy;
  logic [33:0] ssq;
  logic [31:0] mm;
  logic [16:0] root;

  logic signed [53:0] cx, cy;
  logic [31:0] cz;
  logic [15:0] fyaw, ayaw;

  logic [31:0] att_cnt, vld_cnt, last_stamp;

  // Rotation matrix terms from the registered products
  logic [33:0] n2;
  logic signed [33:0] r00, r01, r02, r10, r11, r12;
  logic signed [33:0] p [0:9];

  always_comb begin
    for (int k = 0; k < 10; k++) p[k] = 34'(pr[k]);
    n2  = unsigned'(p[0] + p[1] + p[2] + p[3]);
    r00 = p[0] + p[1] - p[2] - p[3];
    r11 = p[0] - p[1] + p[2] - p[3];
    r01 = (p[4] - p[5]) <<< 1;
    r02 = (p[6] + p[7]) <<< 1;
    r10 = (p[4] + p[5]) <<< 1;
    r12 = (p[8] - p[9]) <<< 1;
  end

  // Early reject reasons known at the request
  always_comb begin
    flags_in            = '0;
    flags_in[FlagMag]   = !s_tuser[0] || (s_tdata[47:0] == 48'd0);
    flags_in[FlagTrust] = require_trusted && !s_tuser[1];
  end

  // Shared multiplier operand select
  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [52:0] mul_p;
  logic [16:0] trial_root;

  assign trial_root = root | (17'd1 << (5'd16 - cnt));
  assign mul_p      = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_PROD: begin
        case (cnt)
          5'd0: begin mul_a = 35'(qw); mul_b = 18'(qw); end
          5'd1: begin mul_a = 35'(qx); mul_b = 18'(qx); end
          5'd2: begin mul_a = 35'(qy); mul_b = 18'(qy); end
          5'd3: begin mul_a = 35'(qz); mul_b = 18'(qz); end
          5'd4: begin mul_a = 35'(qx); mul_b = 18'(qy); end
          5'd5: begin mul_a = 35'(qw); mul_b = 18'(qz); end
          5'd6: begin mul_a = 35'(qx); mul_b = 18'(qz); end
          5'd7: begin mul_a = 35'(qw); mul_b = 18'(qy); end
          5'd8: begin mul_a = 35'(qy); mul_b = 18'(qz); end
          5'd9: begin mul_a = 35'(qw); mul_b = 18'(qx); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_NUM: begin
        case (cnt)
          5'd0: begin mul_a = 35'(sel ? r10 : r00); mul_b = 18'(mx); end
          5'd1: begin mul_a = 35'(sel ? r11 : r01); mul_b = 18'(my); end
          default: begin mul_a = 35'(sel ? r12 : r02); mul_b = 18'(mz); end
        endcase
      end
      S_SQ: begin
        case (cnt)
          5'd0: begin mul_a = 35'(wx); mul_b = 18'(wx); end
          5'd1: begin mul_a = 35'(wy); mul_b = 18'(wy); end
          default: begin
            mul_a = signed'({19'd0, min_norm});
            mul_b = signed'({2'd0, min_norm});
          end
        endcase
      end
      S_ROOT: begin
        mul_a = signed'({18'd0, trial_root});
        mul_b = signed'({1'b0, trial_root});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Divider step and final rounding/saturation
  logic [34:0] dtrial;
  logic        dbit;
  logic [16:0] dqf;
  logic signed [16:0] dres;
  logic [53:0] acc_abs;
  logic [54:0] dadj;

  assign acc_abs = acc[53] ? unsigned'(-acc) : unsigned'(acc);
  assign dadj    = {1'b0, acc_abs} + 55'(n2 >> 1);
  assign dtrial  = {drem, dlow[16]};
  assign dbit    = dtrial >= {1'b0, n2};
  assign dqf     = {dq[15:0], dbit};

  always_comb begin
    if (dsat) begin
      dres = dneg ? -17'sd65536 : 17'sd65535;
    end else if (dneg) begin
      dres = (dqf > 17'd65536) ? -17'sd65536 : -signed'(dqf);
    end else begin
      dres = (dqf > 17'd65535) ? 17'sd65535 : signed'(dqf);
    end
  end

  // CORDIC stage
  logic signed [33:0] cin_x, cin_y;
  logic signed [53:0] sx, sy, cx_n, cy_n;
  logic [31:0] cz_n;

  assign cin_x = sel ? r00 : 34'(wx);
  assign cin_y = sel ? r10 : 34'(wy);
  assign sx    = {{4{cin_x[33]}}, cin_x, 16'd0};
  assign sy    = {{4{cin_y[33]}}, cin_y, 16'd0};

  always_comb begin
    if (cy > 0) begin
      cx_n = cx + (cy >>> cnt);
      cy_n = cy - (cx >>> cnt);
      cz_n = cz + atan_entry(cnt);
    end else begin
      cx_n = cx - (cy >>> cnt);
      cy_n = cy + (cx >>> cnt);
      cz_n = cz - atan_entry(cnt);
    end
  end

  logic [15:0] yaw_rnd;
  logic [31:0] yaw_sum;
  assign yaw_sum = cz_n + 32'h8000;
  assign yaw_rnd = yaw_sum[31:16];

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_PROD;
      S_PROD: if (cnt == 5'd9) state_next = S_CHK;
      S_CHK: begin
        if (flags != 4'd0 || n2 == 34'd0) state_next = S_DONE;
        else state_next = S_NUM;
      end
      S_NUM: if (cnt == 5'd2) state_next = S_DSET;
      S_DSET: state_next = S_DIV;
      S_DIV: if (cnt == 5'd16) state_next = sel ? S_SQ : S_NUM;
      S_SQ: if (cnt == 5'd2) state_next = S_ROOT;
      S_ROOT: if (cnt == 5'd16) state_next = S_HCHK;
      S_HCHK: state_next = (ssq < 34'(mm)) ? S_DONE : S_CSET;
      S_CSET: begin
        if (cin_x == 34'sd0 && cin_y == 34'sd0) state_next = sel ? S_DONE : S_CSET;
        else state_next = S_CROT;
      end
      S_CROT: if (cnt == LastStep) state_next = sel ? S_DONE : S_CSET;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_tready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      require_trusted <= 1'b0;
      min_norm        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgRequireTrusted: require_trusted <= cfg_data[0];
        CfgMinNorm:        min_norm        <= cfg_data;
        default:           min_norm        <= min_norm;
      endcase
    end
  end

  // Datapath sequencing
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        mx    <= signed'(s_tdata[15:0]);
        my    <= signed'(s_tdata[31:16]);
        mz    <= signed'(s_tdata[47:32]);
        qw    <= signed'(s_tdata[63:48]);
        qx    <= signed'(s_tdata[79:64]);
        qy    <= signed'(s_tdata[95:80]);
        qz    <= signed'(s_tdata[111:96]);
        now_r <= s_tdata[143:112];
        flags <= flags_in;
        wx   <= '0;
        wy   <= '0;
        root <= '0;
        fyaw <= '0;
        ayaw <= '0;
        cnt  <= '0;
        sel  <= 1'b0;
      end
      S_PROD: begin
        pr[cnt[3:0]] <= mul_p[31:0];
        cnt <= cnt + 5'd1;
      end
      S_CHK: begin
        flags[FlagQuat] <= (n2 == 34'd0);
        acc <= '0;
        cnt <= '0;
      end
      S_NUM: begin
        acc <= acc + 54'(mul_p);
        cnt <= (cnt == 5'd2) ? 5'd0 : cnt + 5'd1;
      end
      S_DSET: begin
        dneg <= acc[53];
        dsat <= dadj[54:17] >= 38'(n2);
        drem <= dadj[50:17];
        dlow <= dadj[16:0];
        dq   <= '0;
        cnt  <= '0;
      end
      S_DIV: begin
        drem <= dbit ? 34'(dtrial - {1'b0, n2}) : dtrial[33:0];
        dlow <= {dlow[15:0], 1'b0};
        dq   <= dqf;
        cnt  <= (cnt == 5'd16) ? 5'd0 : cnt + 5'd1;
        if (cnt == 5'd16) begin
          acc <= '0;
          if (sel) wy <= dres;
          else wx <= dres;
          sel <= !sel;
        end
      end
      S_SQ: begin
        case (cnt)
          5'd0:    ssq <= 34'(unsigned'(mul_p));
          5'd1:    ssq <= ssq + 34'(unsigned'(mul_p));
          default: mm  <= mul_p[31:0];
        endcase
        cnt <= (cnt == 5'd2) ? 5'd0 : cnt + 5'd1;
      end
      S_ROOT: begin
        if (34'(unsigned'(mul_p)) <= ssq) root <= trial_root;
        cnt <= cnt + 5'd1;
      end
      S_HCHK: begin
        flags[FlagHoriz] <= (ssq < 34'(mm));
        sel <= 1'b0;
        cnt <= '0;
      end
      S_CSET: begin
        cnt <= '0;
        if (cin_x == 34'sd0 && cin_y == 34'sd0) begin
          // atan2 of the origin is zero; yaw already cleared
          sel <= 1'b1;
        end else if (cin_x < 0) begin
          if (cin_y >= 0) begin
            cx <= sy; cy <= -sx; cz <= 32'h40000000;
          end else begin
            cx <= -sy; cy <= sx; cz <= 32'hC0000000;
          end
        end else begin
          cx <= sx; cy <= sy; cz <= '0;
        end
      end
      S_CROT: begin
        cx  <= cx_n;
        cy  <= cy_n;
        cz  <= cz_n;
        cnt <= cnt + 5'd1;
        if (cnt == LastStep) begin
          if (sel) ayaw <= yaw_rnd;
          else fyaw <= yaw_rnd;
          sel <= 1'b1;
        end
      end
      default: cnt <= cnt;
    endcase
  end

  // Result assembly
  logic        hvalid;
  logic [15:0] hn, nyaw, innov;
  logic [31:0] att_next, vld_next, last_next;

  assign hvalid    = (flags == 4'd0);
  assign hn        = root[16] ? 16'hFFFF : root[15:0];
  assign nyaw      = hvalid ? fyaw + 16'h8000 : 16'd0;
  assign innov     = hvalid ? nyaw - ayaw : 16'd0;
  assign att_next  = att_cnt + 32'd1;
  assign vld_next  = hvalid ? vld_cnt + 32'd1 : vld_cnt;
  assign last_next = hvalid ? now_r : last_stamp;

  // Hold result until taken; update counters as it is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      att_cnt    <= '0;
      vld_cnt    <= '0;
      last_stamp <= '0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid   <= 1'b1;
        att_cnt    <= att_next;
        vld_cnt    <= vld_next;
        last_stamp <= last_next;
        m_tuser    <= {flags, hvalid};
        m_tdata    <= {6'd0, last_next, vld_next, att_next, innov, ayaw, nyaw, fyaw,
                       hn, wy, wx};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Checks
  a_valid_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] == (m_tuser[4:1] == 4'd0)))
    else $error("heading_valid disagrees with reject flags");

  a_rot_clean: assert property (@(posedge clk) disable iff (rst)
    state == S_CROT |-> (flags == 4'd0 && cnt <= LastStep))
    else $error("CORDIC running on rejected sample or past last step");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (m_tvalid && state == S_IDLE))
    else $error("result not presented after completion");

endmodule

FILE: tb/sv/tb_tilt_compensated_mag_heading_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tilt_compensated_mag_heading_core
// Drives magnetometer and quaternion requests through the heading core under
// random stalls on both sides. Each request is predicted in a bit-exact model
// of the rotation, magnitude and CORDIC yaw path, and every result is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_tilt_compensated_mag_heading_core;
  import tchd_pkg::*;

  localparam int Steps = (CordicStepsDefault < 24) ? CordicStepsDefault : 24;

  typedef struct {
    logic signed [15:0] mx, my, mz, qw, qx, qy, qz;
    logic               ok, trusted;
    logic [31:0]        now;
  } sample_t;

  typedef struct {
    logic        hv;
    logic [3:0]  flags;
    logic [16:0] wx, wy;
    logic [15:0] hn, fyaw, nyaw, ayaw, innov;
    logic [31:0] attempts, valids, last_time;
  } heading_t;

  // Heading predictor and store of expected headings
  class heading_scoreboard;
    logic        req_trusted;
    logic [15:0] min_norm;
    logic [31:0] attempt_cnt, valid_cnt, last_stamp;
    heading_t    expected_q[$];
    int          errors;

    function new();
      req_trusted = 0; min_norm = 0;
      attempt_cnt = 0; valid_cnt = 0; last_stamp = 0; errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 60) $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    function longint round_div(longint num, longint den);
      longint a, q;
      a = num < 0 ? -num : num;
      q = (a + den / 2) / den;
      return num < 0 ? -q : q;
    endfunction

    function longint clamp17(longint v);
      if (v > 65535) return 65535;
      if (v < -65536) return -65536;
      return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b; r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [31:0] atan_step(int i);
      logic [31:0] tab [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      return tab[i];
    endfunction

    // Vectoring CORDIC atan2 as a 16-bit binary angle
    function logic [15:0] bin_atan2(longint y, longint x);
      longint t, dx, dy;
      logic [31:0] z, r;
      z = 0;
      if (x == 0 && y == 0) return 16'h0;
      x = x * 65536; y = y * 65536;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = 32'h40000000;
        end else begin
          x = -y; y = t; z = 32'hC0000000;
        end
      end
      for (int i = 0; i < Steps; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += atan_step(i);
        end else begin
          x -= dx; y += dy; z -= atan_step(i);
        end
      end
      r = z + 32'h8000;
      return r[31:16];
    endfunction

    // Note an accepted request: predict its heading
    function void note_request(sample_t s);
      heading_t e;
      longint mx, my, mz, w, x, y, z, n2, r00, r01, r02, r10, r11, r12, wx, wy;
      longint unsigned sq, hn, m;
      mx = s.mx; my = s.my; mz = s.mz;
      w = s.qw; x = s.qx; y = s.qy; z = s.qz;
      e = '{default: '0};
      n2 = w*w + x*x + y*y + z*z;
      attempt_cnt++;
      if (!s.ok || (mx == 0 && my == 0 && mz == 0)) e.flags[FlagMag] = 1;
      if (req_trusted && !s.trusted) e.flags[FlagTrust] = 1;
      if (n2 == 0) e.flags[FlagQuat] = 1;
      if (e.flags == 0) begin
        r00 = w*w + x*x - y*y - z*z;
        r01 = 2 * (x*y - w*z);
        r02 = 2 * (x*z + w*y);
        r10 = 2 * (x*y + w*z);
        r11 = w*w - x*x + y*y - z*z;
        r12 = 2 * (y*z - w*x);
        wx = clamp17(round_div(r00*mx + r01*my + r02*mz, n2));
        wy = clamp17(round_div(r10*mx + r11*my + r12*mz, n2));
        sq = wx*wx + wy*wy;
        hn = int_sqrt(sq);
        if (hn > 65535) hn = 65535;
        m = min_norm;
        if (sq < m*m) e.flags[FlagHoriz] = 1;
        e.wx = wx[16:0]; e.wy = wy[16:0]; e.hn = hn[15:0];
        if (e.flags == 0) begin
          e.fyaw = bin_atan2(wy, wx);
          e.nyaw = e.fyaw + 16'h8000;
          e.ayaw = bin_atan2(r10, r00);
          e.innov = e.nyaw - e.ayaw;
        end
      end
      if (e.flags == 0) begin
        valid_cnt++; last_stamp = s.now;
      end
      e.hv = (e.flags == 0);
      e.attempts = attempt_cnt; e.valids = valid_cnt; e.last_time = last_stamp;
      expected_q.push_back(e);
    endfunction

    function void cmp(string name, longint unsigned got, longint unsigned want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endfunction

    // Check a result against the oldest expected heading
    function void check_result(logic [OutDataW-1:0] d, logic [OutUserW-1:0] u);
      heading_t e;
      if (expected_q.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      cmp("heading_valid", u[0], e.hv);
      cmp("reject_flags", u[4:1], e.flags);
      cmp("world_x", d[16:0], e.wx);
      cmp("world_y", d[33:17], e.wy);
      cmp("horizontal_norm", d[49:34], e.hn);
      cmp("field_yaw", d[65:50], e.fyaw);
      cmp("north_yaw", d[81:66], e.nyaw);
      cmp("ahrs_yaw", d[97:82], e.ayaw);
      cmp("innovation", d[113:98], e.innov);
      cmp("attempt_total", d[145:114], e.attempts);
      cmp("valid_total", d[177:146], e.valids);
      cmp("last_valid_time", d[209:178], e.last_time);
    endfunction
  endclass

  logic                clk = 0;
  logic                rst = 1;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [InUserW-1:0]  s_tuser = '0;
  logic                s_tvalid = 0;
  logic                s_tready;
  logic [OutDataW-1:0] m_tdata;
  logic [OutUserW-1:0] m_tuser;
  logic                m_tvalid;
  logic                m_tready = 0;
  logic                cfg_we = 0;
  logic                cfg_index = 0;
  logic [15:0]         cfg_data = '0;

  heading_scoreboard sb = new();
  bit calm = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  tilt_compensated_mag_heading_core u_dut (
    .clk, .rst, .s_tdata, .s_tuser, .s_tvalid, .s_tready,
    .m_tdata, .m_tuser, .m_tvalid, .m_tready, .cfg_we, .cfg_index, .cfg_data
  );

  always #10 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 400;
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CfgRequireTrusted) sb.req_trusted = val[0];
    else sb.min_norm = val;
  endtask

  // Wait until every expected heading has arrived, then let the core settle
  task automatic drain();
    s_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send(sample_t s);
    while (!calm && $urandom_range(99) < 22) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tdata <= {s.now, s.qz, s.qy, s.qx, s.qw, s.mz, s.my, s.mx};
    s_tuser <= {s.trusted, s.ok};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(s);
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    int k;
    k = $urandom_range(99);
    s.mx = 16'($urandom); s.my = 16'($urandom); s.mz = 16'($urandom);
    if (k < 8) begin
      s.mx = 16'(int'($urandom_range(255)) - 128);
      s.my = 16'(int'($urandom_range(255)) - 128);
    end
    if (k == 99) begin
      s.mx = 0; s.my = 0; s.mz = 0;
    end
    s.ok = $urandom_range(99) < 95;
    s.trusted = $urandom_range(99) < 80;
    k = $urandom_range(99);
    s.qw = 16'($urandom); s.qx = 16'($urandom); s.qy = 16'($urandom); s.qz = 16'($urandom);
    if (k < 45) begin
      s.qw = 16'(int'($urandom_range(32767)) - 16384);
      s.qx = 16'(int'($urandom_range(16383)) - 8192);
      s.qy = 16'(int'($urandom_range(16383)) - 8192);
      s.qz = 16'(int'($urandom_range(32767)) - 16384);
    end else if (k < 48) begin
      s.qw = 0; s.qx = 0; s.qy = 0; s.qz = 0;
    end else if (k < 52) begin
      s.qw = 0; s.qx = 0; s.qy = 0; s.qz = 1;
    end
    s.now = $urandom;
    return s;
  endfunction

  function automatic sample_t mk(int mx, int my, int mz, bit ok, bit tr,
                                 int qw, int qx, int qy, int qz, logic [31:0] now);
    sample_t s;
    s.mx = 16'(mx); s.my = 16'(my); s.mz = 16'(mz); s.ok = ok; s.trusted = tr;
    s.qw = 16'(qw); s.qx = 16'(qx); s.qy = 16'(qy); s.qz = 16'(qz); s.now = now;
    return s;
  endfunction

  task automatic random_run(int n, int hold_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_reqs++;
      send(random_sample());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, each reject reason, zero horizontal field
    write_reg(CfgRequireTrusted, 1'b0);
    write_reg(CfgMinNorm, 16'd0);
    send(mk(1000, 0, 0, 1, 1, 16384, 0, 0, 0, 32'd0));
    send(mk(0, 1000, 0, 1, 0, 16384, 0, 0, 0, 32'hFFFFFFFF));
    send(mk(1000, 0, 0, 0, 1, 16384, 0, 0, 0, 32'd5));
    send(mk(0, 0, 0, 1, 1, 16384, 0, 0, 0, 32'd6));
    send(mk(500, 500, 500, 1, 1, 0, 0, 0, 0, 32'd7));
    send(mk(0, 0, 3000, 1, 1, 16384, 0, 0, 0, 32'd8));
    send(mk(-32768, -32768, -32768, 1, 1, -32768, -32768, -32768, -32768, 32'd9));
    send(mk(32767, 32767, 32767, 1, 1, 32767, 32767, 32767, 32767, 32'd10));
    send(mk(32767, -32768, 0, 1, 1, 1, 0, 0, 0, 32'h80000000));
    send(mk(-32768, 32767, -1, 1, 1, 0, 0, 0, -32768, 32'h7FFFFFFF));
    send(mk(-1000, 0, 0, 1, 1, 16384, 0, 0, 0, 32'd11));
    send(mk(-1000, -1, 0, 1, 1, 11585, 0, 0, 11585, 32'd12));
    send(mk(1, 0, 0, 1, 1, 0, 16384, 0, 0, 32'd13));
    send(mk(0, -1, 0, 1, 1, 0, 0, 16384, 0, 32'd14));
    send(mk(0, 0, 1, 1, 1, -16384, 0, 0, 0, 32'd15));
    drain();
    write_reg(CfgRequireTrusted, 1'b1);
    write_reg(CfgMinNorm, 16'd1000);
    send(mk(1000, 0, 0, 1, 0, 16384, 0, 0, 0, 32'd20));
    send(mk(999, 0, 0, 1, 1, 16384, 0, 0, 0, 32'd21));
    send(mk(1000, 0, 0, 1, 1, 16384, 0, 0, 0, 32'd22));
    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd23));
    drain();

    // Random phases over several register settings
    write_reg(CfgRequireTrusted, 1'b0);
    write_reg(CfgMinNorm, 16'd0);
    random_run(250, 120);
    drain();
    random_run(150, -1);
    drain();
    write_reg(CfgRequireTrusted, 1'b1);
    write_reg(CfgMinNorm, 16'd65535);
    random_run(200, -1);
    drain();
    write_reg(CfgMinNorm, 16'd0);
    calm = 1;
    random_run(200, -1);
    calm = 0;
    random_run(200, -1);
    drain();
    write_reg(CfgRequireTrusted, 1'b0);
    write_reg(CfgMinNorm, 16'd1500);
    random_run(500, 300);
    drain();
    write_reg(CfgRequireTrusted, 1'b1);
    write_reg(CfgMinNorm, 16'($urandom_range(40000)));
    random_run(450, -1);

    // Wait for the tail, then let the core sit idle before the verdict
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_tilt_compensated_mag_heading_core OK");
    end else begin
      $display("tb_tilt_compensated_mag_heading_core NOT OK");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("tb_tilt_compensated_mag_heading_core NOT OK");
    $finish;
  end

endmodule
